// ===== rtl/ifl_pkg.sv =====
// ----------------------------------------------------------------------------
// ifl_pkg
// Shared widths, entry type and sequencer codes for the interval union block.
// ----------------------------------------------------------------------------
package ifl_pkg;
   localparam int START_W = 32;
   localparam int LEN_W   = 31;
   localparam int TOTAL_W = 33;
   localparam int REACH_W = 34;   // start + length, signed

   typedef struct packed {
      logic signed [START_W-1:0] start;
      logic [LEN_W-1:0]          len;
   } entry_type;

   localparam int ENTRY_W = START_W + LEN_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SHIFT = 3'd1;
   localparam logic [2:0] ST_PLACE = 3'd2;
   localparam logic [2:0] ST_SWEEP = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;
endpackage

// ===== rtl/interval_union_length.sv =====
// ----------------------------------------------------------------------------
// interval_union_length
// Insertion-sorts intervals into a RAM, then sweeps it for the union length.
// ----------------------------------------------------------------------------
// An insert into an empty store is written directly; else entries with larger
//    starts move up one slot, top first (one RAM read/write each); then it is written.
// The final word adds a sweep over all held entries, then the result word.
// Throughput is bound by the single RAM read port: one entry touched a cycle.
// Synchronous reset clears count, overflow flag and sequencer; the RAM is not
// cleared, entries at or beyond the count are never read.
module interval_union_length #(
   parameter int MAX_INTERVALS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [ifl_pkg::START_W-1:0] req_start_req,
   input  logic [ifl_pkg::LEN_W-1:0]         req_length,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ifl_pkg::TOTAL_W-1:0]       rsp_covered_total,
   output logic                              rsp_overflowed
);
   import ifl_pkg::*;

   localparam int AW = $clog2(MAX_INTERVALS);
   localparam int CW = $clog2(MAX_INTERVALS + 1);

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          proc_ff, proc_in;
   logic          first_ff, first_in;
   entry_type     new_ff, new_in;
   logic          last_ff, last_in;
   logic signed [REACH_W-1:0] reach_ff, reach_in;
   logic [TOTAL_W-1:0]        total_ff, total_in;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   entry_type     wr_data, rd_data;
   logic [ENTRY_W-1:0] rd_raw;

   logic signed [REACH_W-1:0] e_end;
   logic                      issue;

   assign rd_data = entry_type'(rd_raw);
   assign e_end = REACH_W'(rd_data.start) + $signed({3'b000, rd_data.len});
   assign issue = (idx_ff < count_ff);

   ifl_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_INTERVALS)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = (state_ff == ST_OUT);
   assign rsp_covered_total = total_ff;
   assign rsp_overflowed    = ovf_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      pos_in   = pos_ff;
      idx_in   = idx_ff;
      proc_in  = 1'b0;
      first_in = first_ff;
      new_in   = new_ff;
      last_in  = last_ff;
      reach_in = reach_ff;
      total_in = total_ff;
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = new_ff;
      rd_en    = 1'b0;
      rd_addr  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               new_in.start = req_start_req;
               new_in.len   = req_length;
               last_in      = req_last;
               idx_in       = '0;
               total_in     = '0;
               if (count_ff == CW'(MAX_INTERVALS)) begin
                  ovf_in = 1'b1;
                  if (req_last) state_in = ST_SWEEP;
               end else if (count_ff == '0) begin
                  wr_en        = 1'b1;
                  wr_data.start = req_start_req;
                  wr_data.len   = req_length;
                  count_in     = CW'(1);
                  if (req_last) state_in = ST_SWEEP;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = AW'(count_ff - CW'(1));
                  pos_in   = AW'(count_ff - CW'(1));
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            wr_en = 1'b1;
            if (rd_data.start > new_ff.start) begin
               // move the larger entry up one slot, keep walking down
               wr_addr = pos_ff + AW'(1);
               wr_data = rd_data;
               if (pos_ff == '0) begin
                  state_in = ST_PLACE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = pos_ff - AW'(1);
                  pos_in  = pos_ff - AW'(1);
               end
            end else begin
               wr_addr  = pos_ff + AW'(1);
               count_in = count_ff + CW'(1);
               state_in = last_ff ? ST_SWEEP : ST_IDLE;
            end
         end
         ST_PLACE: begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
            state_in = last_ff ? ST_SWEEP : ST_IDLE;
         end
         ST_SWEEP: begin
            if (issue) begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff[AW-1:0];
               idx_in   = idx_ff + CW'(1);
               proc_in  = 1'b1;
               first_in = (idx_ff == '0);
            end
            if (proc_ff) begin
               if (first_ff) begin
                  reach_in = e_end;
                  total_in = TOTAL_W'(rd_data.len);
               end else if (REACH_W'(rd_data.start) >= reach_ff) begin
                  reach_in = e_end;
                  total_in = total_ff + TOTAL_W'(rd_data.len);
               end else if (e_end > reach_ff) begin
                  reach_in = e_end;
                  total_in = total_ff + TOTAL_W'(e_end - reach_ff);
               end
            end
            if (!issue && !proc_ff) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         proc_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         proc_ff  <= proc_in;
      end
      pos_ff   <= pos_in;
      idx_ff   <= idx_in;
      first_ff <= first_in;
      new_ff   <= new_in;
      last_ff  <= last_in;
      reach_ff <= reach_in;
      total_ff <= total_in;
   end
endmodule

// ===== rtl/ifl_ram.sv =====
// ----------------------------------------------------------------------------
// ifl_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ifl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

// ===== rtl/ifl_checker.sv =====
// ----------------------------------------------------------------------------
// ifl_checker
// Port-level checks for interval_union_length, bound to the top level.
// ----------------------------------------------------------------------------
module ifl_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        req_last,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [ifl_pkg::TOTAL_W-1:0] rsp_covered_total
);
   import ifl_pkg::*;

   // no result may come straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_covered_total))
      else $error("stalled result changed");

   // input is closed while a result is pending
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open with result pending");

   // a final word always starts the sweep
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last |=> req_stall)
      else $error("input open after final word");
endmodule

bind interval_union_length ifl_checker u_ifl_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_last          (req_last),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_covered_total (rsp_covered_total)
);

// ===== tb/sv/interval_union_length_tb.sv =====
// ----------------------------------------------------------------------------
// interval_union_length_tb
// Feeds sets of intervals to the block and checks each union length and drop
// flag against a local insertion-sort and sweep predictor. Both sides idle at
// random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module interval_union_length_tb;
   import ifl_pkg::*;

   localparam int CAPACITY    = 1024;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      logic signed [START_W-1:0] start;
      logic [LEN_W-1:0]          len;
      logic                      last;
   } interval_word;

   typedef struct {
      logic [TOTAL_W-1:0] covered;
      logic               dropped;
   } union_word;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [START_W-1:0] req_start_req = '0;
   logic [LEN_W-1:0] req_length = '0;
   logic req_last = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [TOTAL_W-1:0] rsp_covered_total;
   logic rsp_overflowed;

   interval_word pending_intervals[$];
   union_word    expected_unions[$];
   entry_type    held_intervals[$];
   logic         drop_seen = 0;
   int           mismatches = 0;
   int           unions_seen = 0;
   int           sets_queued = 0;
   int           cycle_count = 0;

   interval_union_length #(.MAX_INTERVALS(CAPACITY)) u_dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------- predictor ----------------
   function automatic logic [TOTAL_W-1:0] union_length();
      longint reach, total, s, e;
      if (held_intervals.size() == 0) return '0;
      reach = longint'(held_intervals[0].start) + longint'(held_intervals[0].len);
      total = longint'(held_intervals[0].len);
      for (int i = 1; i < held_intervals.size(); i++) begin
         s = longint'(held_intervals[i].start);
         e = s + longint'(held_intervals[i].len);
         if (s >= reach) begin
            total += longint'(held_intervals[i].len);
            reach = e;
         end else if (e > reach) begin
            total += e - reach;
            reach = e;
         end
      end
      return total[TOTAL_W-1:0];
   endfunction

   task automatic absorb_interval(input logic signed [START_W-1:0] s,
                                  input logic [LEN_W-1:0] l, input logic fin);
      int pos;
      entry_type ent;
      union_word res;
      if (held_intervals.size() >= CAPACITY) begin
         drop_seen = 1;
      end else begin
         pos = held_intervals.size();
         while (pos > 0 && held_intervals[pos-1].start > s) pos--;
         ent.start = s;
         ent.len = l;
         held_intervals.insert(pos, ent);
      end
      if (fin) begin
         res.covered = union_length();
         res.dropped = drop_seen;
         expected_unions.push_back(res);
         held_intervals.delete();
         drop_seen = 0;
      end
   endtask

   // ---------------- stimulus ----------------
   task automatic add_interval(input logic signed [START_W-1:0] s,
                               input logic [LEN_W-1:0] l, input logic fin);
      interval_word w;
      w.start = s;
      w.len = l;
      w.last = fin;
      pending_intervals.push_back(w);
      if (fin) sets_queued++;
   endtask

   task automatic add_random_set(input int n);
      logic signed [START_W-1:0] base;
      logic [LEN_W-1:0] l;
      logic signed [START_W-1:0] s;
      base = $urandom;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 3))
            0: s = $urandom;
            default: s = base + $urandom_range(0, 300);
         endcase
         case ($urandom_range(0, 5))
            0: l = LEN_W'($urandom);
            1: l = '0;
            default: l = LEN_W'($urandom_range(0, 120));
         endcase
         add_interval(s, l, i == n - 1);
      end
   endtask

   // ascending starts keep inserts cheap; runs past capacity so the final
   // word itself is dropped
   task automatic add_overflow_set(input int n);
      logic signed [START_W-1:0] s;
      s = -32'sd2000000;
      for (int i = 0; i < n; i++) begin
         s = s + $urandom_range(0, 40);
         add_interval(s, LEN_W'($urandom_range(0, 100)), i == n - 1);
      end
   endtask

   // ---------------- driver ----------------
   int burst_left = 0;
   int gap_left = 0;
   logic next_valid;
   interval_word cur;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else begin
         next_valid = req_valid;
         if (req_valid && !req_stall) begin
            absorb_interval(req_start_req, req_length, req_last);
            next_valid = 0;
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_intervals.size() > 0) begin
               cur = pending_intervals.pop_front();
               req_start_req <= cur.start;
               req_length <= cur.len;
               req_last <= cur.last;
               next_valid = 1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
         req_valid <= next_valid;
      end
   end

   // ---------------- result stall pattern ----------------
   int hold_left = 0;
   logic hold_done = 0;
   int stall_mode = 0;
   int mode_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else if (!hold_done && unions_seen == 6) begin
         hold_done <= 1;
         hold_left <= 2500;
         rsp_stall <= 1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(10, 80);
         end else begin
            mode_left = mode_left - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 0;
            1: rsp_stall <= 1'($urandom_range(0, 1));
            default: rsp_stall <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   // ---------------- monitor ----------------
   union_word want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         unions_seen <= unions_seen + 1;
         if (expected_unions.size() == 0) begin
            $display("%0t: unexpected word total=%0d overflowed=%0b", $time,
                     rsp_covered_total, rsp_overflowed);
            mismatches = mismatches + 1;
         end else begin
            want = expected_unions.pop_front();
            if (rsp_covered_total !== want.covered) begin
               $display("%0t: covered_total expected %0d actual %0d", $time,
                        want.covered, rsp_covered_total);
               mismatches = mismatches + 1;
            end
            if (rsp_overflowed !== want.dropped) begin
               $display("%0t: overflowed expected %0b actual %0b", $time,
                        want.dropped, rsp_overflowed);
               mismatches = mismatches + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("interval_union_length_tb NOT OK");
         $finish;
      end
   end

   // ---------------- sequence ----------------
   initial begin
      // extremes of the range
      add_interval(32'sh8000_0000, 31'h7FFF_FFFF, 1'b1);
      add_interval(32'sh7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);
      add_interval(32'sh7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
      add_interval(32'sd0, 31'h7FFF_FFFF, 1'b0);
      add_interval(32'sh8000_0000, 31'h7FFF_FFFF, 1'b1);
      // equal starts
      add_interval(32'sd5, 31'd10, 1'b0);
      add_interval(32'sd5, 31'd3, 1'b0);
      add_interval(32'sd5, 31'd20, 1'b1);
      // zero length
      add_interval(32'sd100, 31'd0, 1'b1);
      add_interval(32'sd0, 31'd0, 1'b0);
      add_interval(32'sd10, 31'd5, 1'b0);
      add_interval(32'sd3, 31'd0, 1'b1);
      // mostly descending arrival: touching, disjoint, nested
      add_interval(32'sd30, 31'd2, 1'b0);
      add_interval(32'sd10, 31'd5, 1'b0);
      add_interval(32'sd0, 31'd10, 1'b0);
      add_interval(32'sd1, 31'd3, 1'b0);
      add_interval(-32'sd4, 31'd2, 1'b1);

      for (int i = 0; i < 20; i++) add_random_set($urandom_range(1, 8));
      add_overflow_set(CAPACITY + 6);
      while (pending_intervals.size() < 1270) begin
         if ($urandom_range(0, 9) == 0) add_random_set($urandom_range(9, 40));
         else add_random_set($urandom_range(1, 8));
      end

      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // every queued set ends in exactly one result word
      while (unions_seen < sets_queued)
         @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatches == 0) begin
         $display("interval_union_length_tb OK");
      end else begin
         $display("interval_union_length_tb NOT OK");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/ifl_pkg.sv
rtl/ifl_ram.sv
rtl/interval_union_length.sv
rtl/ifl_checker.sv
tb/sv/interval_union_length_tb.sv
